FILE: rtl/gdqp_pkg.sv
// Shared types, constants and helper functions for the gray decimate/quantize/pack unit.
// Used by every module in rtl; depends on nothing.
`default_nettype none

package gdqp_pkg;

    // Frame size limits and the widths that follow from them.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int FACTOR_W   = 4;
    localparam int PHASE_W    = 3;
    localparam int FILL_W     = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_FACTOR = 8;

    // Queue between front and back.
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR = 2'd0,
        CFG_MODE   = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    // Output depth codes.
    typedef enum logic [1:0] {
        GRAY_1 = 2'd0,
        GRAY_2 = 2'd1,
        GRAY_4 = 2'd2,
        GRAY_8 = 2'd3
    } t_gray_mode;

    // Configuration as seen by the datapath, already clamped into range.
    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        t_gray_mode          mode;
        logic [WDIM_W-1:0]   width;
        logic [HDIM_W-1:0]   height;
    } t_cfg;

    // One kept pixel handed from front to back.
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             last;
    } t_qent;

    // Level = (x + 127) / 255 for x = p * maxl with maxl <= 15.
    // The quotient estimate x >> 8 is low by at most one, so one compare fixes it.
    function automatic logic [3:0] quant_div255(input logic [11:0] x);
        logic [3:0] q0;
        logic [8:0] r;
        q0 = x[11:8];
        r  = {1'b0, x[7:0]} + {5'd0, q0};
        return (r >= 9'd255) ? (q0 + 4'd1) : q0;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gdqp_queue.sv
// Short register queue that decouples the pixel front end from the packing back end.
// Depends on gdqp_pkg for the entry type and depth.
`default_nettype none

module gdqp_queue
    import gdqp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_clear,
    input  wire logic  i_push,
    input  wire t_qent i_data,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_qent      o_data
);

    t_qent                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count,  n_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_clear) begin
            n_wr_ptr = '0;
            n_rd_ptr = '0;
            n_count  = '0;
        end else begin
            if (i_push) begin
                n_wr_ptr = r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                n_rd_ptr = r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                n_count = r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                n_count = r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push && !i_clear) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gdqp_front.sv
// Front end: accepts source pixels, tracks raster position and decimation phase,
// and queues kept pixels with their end-of-frame flag. Depends on gdqp_pkg.
`default_nettype none

module gdqp_front
    import gdqp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_restart,
    input  wire logic             i_accept,
    input  wire logic [PIX_W-1:0] i_luma,
    output logic                  o_push,
    output t_qent                 o_entry
);

    logic [COL_W-1:0]   r_col,       n_col;
    logic [ROW_W-1:0]   r_row,       n_row;
    logic [PHASE_W-1:0] r_col_phase, n_col_phase;
    logic [PHASE_W-1:0] r_row_phase, n_row_phase;

    logic               kept;
    logic               last;
    logic               col_wrap;
    logic               row_wrap;
    logic               col_phase_wrap;
    logic               row_phase_wrap;

    // Classify the current pixel: kept on phase zero, last when the next kept
    // row and column would both fall outside the frame.
    always_comb begin
        kept = (r_col_phase == '0) && (r_row_phase == '0);
        last = ((WDIM_W + 1)'(r_col) + (WDIM_W + 1)'(i_cfg.factor)
                   >= (WDIM_W + 1)'(i_cfg.width))
            && ((HDIM_W + 1)'(r_row) + (HDIM_W + 1)'(i_cfg.factor)
                   >= (HDIM_W + 1)'(i_cfg.height));
        col_wrap = (WDIM_W + 1)'(r_col) + (WDIM_W + 1)'(1) >= (WDIM_W + 1)'(i_cfg.width);
        row_wrap = (HDIM_W + 1)'(r_row) + (HDIM_W + 1)'(1) >= (HDIM_W + 1)'(i_cfg.height);
        col_phase_wrap = ({1'b0, r_col_phase} + 4'd1) >= i_cfg.factor;
        row_phase_wrap = ({1'b0, r_row_phase} + 4'd1) >= i_cfg.factor;
    end

    assign o_push        = i_accept && kept;
    assign o_entry.luma  = i_luma;
    assign o_entry.last  = last;

    // Raster position advance with wrap at the frame bounds.
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        if (i_restart) begin
            n_col       = '0;
            n_row       = '0;
            n_col_phase = '0;
            n_row_phase = '0;
        end else if (i_accept) begin
            if (col_wrap) begin
                n_col       = '0;
                n_col_phase = '0;
                if (row_wrap) begin
                    n_row       = '0;
                    n_row_phase = '0;
                end else begin
                    n_row       = r_row + ROW_W'(1);
                    n_row_phase = row_phase_wrap ? '0 : r_row_phase + PHASE_W'(1);
                end
            end else begin
                n_col       = r_col + COL_W'(1);
                n_col_phase = col_phase_wrap ? '0 : r_col_phase + PHASE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gdqp_back.sv
// Back end: quantizes kept pixels (8-bit mode passes luma through), packs levels MSB first
// into bytes and holds the result in an output register. Depends on gdqp_pkg.
`default_nettype none

module gdqp_back
    import gdqp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_gray_mode       i_mode,
    input  wire logic             i_restart,
    input  wire logic             i_q_valid,
    input  wire t_qent            i_q_data,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [PIX_W-1:0]      o_packed_byte,
    output logic                  o_frame_end
);

    logic [PIX_W-1:0]  r_acc,      n_acc;
    logic [FILL_W-1:0] r_fill,     n_fill;
    logic              r_out_vld,  n_out_vld;
    logic [PIX_W-1:0]  r_out_byte, n_out_byte;
    logic              r_out_end,  n_out_end;

    logic [3:0]        bits;
    logic [3:0]        maxl;
    logic [11:0]       scaled;
    logic [3:0]        quot;
    logic [3:0]        lvl;
    logic [FILL_W-1:0] shift;
    logic [PIX_W-1:0]  merged;
    logic [FILL_W:0]   fill_sum;
    logic              emit;

    // Level count and width for the selected depth.
    always_comb begin
        unique case (i_mode)
            GRAY_1: begin
                bits = 4'd1;
                maxl = 4'd1;
            end
            GRAY_2: begin
                bits = 4'd2;
                maxl = 4'd3;
            end
            GRAY_4: begin
                bits = 4'd4;
                maxl = 4'd15;
            end
            GRAY_8: begin
                bits = 4'd8;
                maxl = 4'd15;
            end
        endcase
    end

    // Quantize and merge into the partial byte.
    always_comb begin
        scaled   = 12'(i_q_data.luma) * 12'(maxl) + 12'd127;
        quot     = quant_div255(scaled);
        lvl      = (quot > maxl) ? maxl : quot;
        shift    = FILL_W'(4'd8 - bits - {1'b0, r_fill});
        merged   = r_acc | (PIX_W'(lvl) << shift);
        fill_sum = {1'b0, r_fill} + bits;
        emit     = (i_mode == GRAY_8) || (fill_sum >= 4'd8) || i_q_data.last;
    end

    // Take a queued pixel whenever the output register is free or draining.
    assign o_q_pop = i_q_valid && (!r_out_vld || !i_stall);

    always_comb begin
        n_acc      = r_acc;
        n_fill     = r_fill;
        n_out_vld  = r_out_vld && i_stall;
        n_out_byte = r_out_byte;
        n_out_end  = r_out_end;
        if (i_restart) begin
            n_acc     = '0;
            n_fill    = '0;
            n_out_vld = 1'b0;
        end else if (o_q_pop) begin
            if (emit) begin
                n_out_vld  = 1'b1;
                n_out_byte = (i_mode == GRAY_8) ? i_q_data.luma : merged;
                n_out_end  = i_q_data.last;
                n_acc      = '0;
                n_fill     = '0;
            end else begin
                n_acc  = merged;
                n_fill = fill_sum[FILL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
        end
    end

    // Output payload holds while stalled; no reset needed.
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

    assign o_valid       = r_out_vld;
    assign o_packed_byte = r_out_byte;
    assign o_frame_end   = r_out_end;

endmodule

`default_nettype wire

FILE: rtl/gray_decimate_quantize_pack_unit.sv
// Gray decimate/quantize/pack unit: takes one source pixel per cycle while o_stall is low.
// The pixel that completes a result byte passes through the front-to-back queue and then
// the output register before the byte appears.
// Input stalls only when the four-entry queue is full behind a stalled output.
// Synchronous active-low reset sets factor 1, 8-bit mode, 640 x 480 and clears position.
`default_nettype none

module gray_decimate_quantize_pack_unit
    import gdqp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PIX_W-1:0]      i_luma,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [PIX_W-1:0]           o_packed_byte,
    output logic                       o_frame_end
);

    t_cfg   r_cfg, n_cfg;
    logic   restart;
    logic   accept;
    logic   push;
    t_qent  push_data;
    logic   q_full;
    logic   q_valid;
    t_qent  q_data;
    logic   q_pop;

    // Configuration registers, stored already clamped into range.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FACTOR: begin
                    if (i_cfg_data[FACTOR_W-1:0] == '0) begin
                        n_cfg.factor = FACTOR_W'(1);
                    end else if (i_cfg_data[FACTOR_W-1:0] > FACTOR_W'(MAX_FACTOR)) begin
                        n_cfg.factor = FACTOR_W'(MAX_FACTOR);
                    end else begin
                        n_cfg.factor = i_cfg_data[FACTOR_W-1:0];
                    end
                end
                CFG_MODE: begin
                    n_cfg.mode = t_gray_mode'(i_cfg_data[1:0]);
                end
                CFG_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        n_cfg.width = WDIM_W'(1);
                    end else if (32'(i_cfg_data) > MAX_WIDTH) begin
                        n_cfg.width = WDIM_W'(MAX_WIDTH);
                    end else begin
                        n_cfg.width = WDIM_W'(i_cfg_data);
                    end
                end
                CFG_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        n_cfg.height = HDIM_W'(1);
                    end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
                        n_cfg.height = HDIM_W'(MAX_HEIGHT);
                    end else begin
                        n_cfg.height = HDIM_W'(i_cfg_data);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.factor <= FACTOR_W'(1);
            r_cfg.mode   <= GRAY_8;
            r_cfg.width  <= WDIM_W'(640);
            r_cfg.height <= HDIM_W'(480);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Every register write restarts the frame.
    assign restart = i_cfg_we;
    assign accept  = i_valid && !q_full;
    assign o_stall = q_full;

    gdqp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (restart),
        .i_accept  (accept),
        .i_luma    (i_luma),
        .o_push    (push),
        .o_entry   (push_data)
    );

    gdqp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (restart),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    gdqp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_cfg.mode),
        .i_restart     (restart),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_byte (o_packed_byte),
        .o_frame_end   (o_frame_end)
    );

endmodule

`default_nettype wire
